FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of the buffer manager.
// Depends on nothing; each macro takes the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/lpbm_pkg.sv
// Shared types and constants of the LRU page buffer manager.
// Depends on nothing; used by the cell, the top level and the checker.
package lpbm_pkg;

    localparam int FRAMES      = 64;
    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int RANK_W      = FRAME_W;
    localparam int PAGE_W      = 20;
    localparam int FRAME_OUT_W = 6;
    localparam int CNT_W       = 32;
    localparam int IDX_CMP_W   = (FRAME_W > FRAME_OUT_W) ? FRAME_W : FRAME_OUT_W;

    localparam logic [1:0] OP_READ_FIX  = 2'd0;
    localparam logic [1:0] OP_WRITE_FIX = 2'd1;
    localparam logic [1:0] OP_SET_DIRTY = 2'd2;

    typedef struct packed {
        logic [1:0]             operation;
        logic [PAGE_W-1:0]      page_number;
        logic [FRAME_OUT_W-1:0] frame_number;
    } req_t;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic                   hit;
        logic                   evicted;
        logic [PAGE_W-1:0]      evicted_page;
        logic                   evicted_dirty;
        logic [CNT_W-1:0]       hit_count;
        logic [CNT_W-1:0]       io_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_EVICT,
        CMD_LOAD,
        CMD_MARK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   write;
        logic [PAGE_W-1:0]      page;
        logic [RANK_W-1:0]      limit;
        logic [FRAME_OUT_W-1:0] mark_idx;
    } cmd_t;

    typedef struct packed {
        logic              match;
        logic              victim;
        logic              free_first;
        logic [RANK_W-1:0] hit_rank;
        logic [PAGE_W-1:0] ev_page;
        logic              ev_dirty;
    } cell_view_t;

endpackage

FILE: rtl/lru_page_buffer_manager.sv
// Top level of the LRU page buffer manager: control, counters and the row of cells.
// Depends on lpbm_pkg and lpbm_cell.
//
//   Channel  Valid      Stall      Payload
//   request  req_valid  req_stall  req (req_t)
//   result   rsp_valid  rsp_stall  rsp (rsp_t)
//
// Each operation goes through ST_LOOK for the tag and rank compare in all cells,
// then ST_UPDATE for the recency update and the result. The next request is taken
// in ST_UPDATE once the output register is free, as the last one commits.
// Reset clears all frames to unused and the counters to zero; no clearing pass.
// A stalled result holds the update cycle until the output register is free.
module lru_page_buffer_manager (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lpbm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lpbm_pkg::rsp_t rsp
);
    import lpbm_pkg::*;

    state_t             state_reg, state_next;
    req_t               req_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg;
    logic [CNT_W-1:0]   hits_reg, hits_next;
    logic [CNT_W-1:0]   io_reg, io_next;
    logic               accept, out_free, commit;
    cmd_kind_t          kind;
    cmd_t               cmd;

    logic [FRAMES:0]    used_chain;
    cell_view_t         views [FRAMES];

    logic               any_hit, ev_dirty, full;
    logic [RANK_W-1:0]  hit_rank;
    logic [PAGE_W-1:0]  ev_page;
    logic [FRAME_W-1:0] hit_idx, victim_idx, free_idx;
    logic [CNT_W:0]     io_sum;

    assign used_chain[0] = 1'b1;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lpbm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (FRAME_W'(i)),
            .prev_used (used_chain[i]),
            .page_cmp  (req_reg.page_number),
            .cmd       (cmd),
            .used      (used_chain[i+1]),
            .view      (views[i])
        );
    end

    always_comb
    begin
        any_hit    = 1'b0;
        ev_dirty   = 1'b0;
        hit_rank   = '0;
        ev_page    = '0;
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            any_hit    = any_hit | views[i].match;
            ev_dirty   = ev_dirty | views[i].ev_dirty;
            hit_rank   = hit_rank | views[i].hit_rank;
            ev_page    = ev_page | views[i].ev_page;
            hit_idx    = hit_idx | (views[i].match ? FRAME_W'(i) : '0);
            victim_idx = victim_idx | (views[i].victim ? FRAME_W'(i) : '0);
            free_idx   = free_idx | (views[i].free_first ? FRAME_W'(i) : '0);
        end
    end

    assign full     = used_chain[FRAMES];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = req_valid && !req_stall;
    assign io_sum   = {1'b0, io_reg} + (CNT_W + 1)'(kind == CMD_EVICT || kind == CMD_LOAD)
                      + (CNT_W + 1)'(kind == CMD_EVICT && ev_dirty);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_LOOK : ST_IDLE;
            ST_LOOK:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req_stall = 1'b0;
            ST_LOOK:   req_stall = 1'b1;
            ST_UPDATE:
            begin
                req_stall = !out_free;
                commit    = out_free;
            end
            default:   req_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        kind     = CMD_NONE;
        rsp_next = '0;
        unique case (req_reg.operation) inside
            OP_READ_FIX, OP_WRITE_FIX:
            begin
                if (any_hit)
                begin
                    kind           = CMD_HIT;
                    rsp_next.frame = FRAME_OUT_W'(hit_idx);
                    rsp_next.hit   = 1'b1;
                end
                else if (full)
                begin
                    kind                   = CMD_EVICT;
                    rsp_next.frame         = FRAME_OUT_W'(victim_idx);
                    rsp_next.evicted       = 1'b1;
                    rsp_next.evicted_page  = ev_page;
                    rsp_next.evicted_dirty = ev_dirty;
                end
                else
                begin
                    kind           = CMD_LOAD;
                    rsp_next.frame = FRAME_OUT_W'(free_idx);
                end
            end
            OP_SET_DIRTY:
            begin
                kind           = CMD_MARK;
                rsp_next.frame = req_reg.frame_number;
            end
            default:
            begin
                kind = CMD_NONE;
            end
        endcase

        hits_next = hits_reg;
        if (kind == CMD_HIT && hits_reg != '1)
        begin
            hits_next = hits_reg + CNT_W'(1);
        end
        io_next            = io_sum[CNT_W] ? '1 : io_sum[CNT_W-1:0];
        rsp_next.hit_count = hits_next;
        rsp_next.io_count  = io_next;
    end

    always_comb
    begin
        cmd.kind     = commit ? kind : CMD_NONE;
        cmd.write    = req_reg.operation == OP_WRITE_FIX;
        cmd.page     = req_reg.page_number;
        cmd.limit    = hit_rank;
        cmd.mark_idx = req_reg.frame_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            hits_reg      <= '0;
            io_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
                hits_reg      <= hits_next;
                io_reg        <= io_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/lpbm_cell.sv
// One frame of the buffer pool: its page tag, flags and recency rank.
// Depends on lpbm_pkg; takes the used bit of the previous cell in the row.
module lpbm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lpbm_pkg::FRAME_W-1:0]  idx,
    input  logic                          prev_used,
    input  logic [lpbm_pkg::PAGE_W-1:0]   page_cmp,
    input  lpbm_pkg::cmd_t                cmd,
    output logic                          used,
    output lpbm_pkg::cell_view_t          view
);
    import lpbm_pkg::*;

    logic              used_reg, used_next;
    logic              dirty_reg, dirty_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              match_reg, victim_reg, free_reg;
    logic              sel;

    assign used = used_reg;

    always_comb
    begin
        case (cmd.kind)
            CMD_HIT:   sel = match_reg;
            CMD_EVICT: sel = victim_reg;
            CMD_LOAD:  sel = free_reg;
            default:   sel = 1'b0;
        endcase
    end

    always_comb
    begin
        used_next  = used_reg;
        dirty_next = dirty_reg;
        page_next  = page_reg;
        rank_next  = rank_reg;
        case (cmd.kind)
            CMD_HIT:
            begin
                if (sel)
                begin
                    rank_next  = '0;
                    dirty_next = dirty_reg | cmd.write;
                end
                else if (used_reg && rank_reg < cmd.limit)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            CMD_EVICT, CMD_LOAD:
            begin
                if (sel)
                begin
                    used_next  = 1'b1;
                    dirty_next = cmd.write;
                    page_next  = cmd.page;
                    rank_next  = '0;
                end
                else if (used_reg)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            CMD_MARK:
            begin
                if (used_reg && IDX_CMP_W'(idx) == IDX_CMP_W'(cmd.mark_idx))
                begin
                    dirty_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= 1'b0;
            dirty_reg  <= 1'b0;
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            dirty_reg  <= dirty_next;
            match_reg  <= used_reg && page_reg == page_cmp;
            victim_reg <= used_reg && rank_reg == RANK_W'(FRAMES - 1);
            free_reg   <= !used_reg && prev_used;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        rank_reg <= rank_next;
    end

    always_comb
    begin
        view.match      = match_reg;
        view.victim     = victim_reg;
        view.free_first = free_reg;
        view.hit_rank   = match_reg ? rank_reg : '0;
        view.ev_page    = victim_reg ? page_reg : '0;
        view.ev_dirty   = victim_reg & dirty_reg;
    end

endmodule

FILE: rtl/lpbm_checker.sv
// Port-level checker for the LRU page buffer manager, bound to the top level.
// Depends on lpbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpbm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input lpbm_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lpbm_pkg::rsp_t rsp
);
    import lpbm_pkg::*;

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)
    `ASSERT_ALWAYS(a_hit_no_evict, clk, rst_n, !rsp_valid || !(rsp.hit && rsp.evicted))
    `ASSERT_ALWAYS(a_evict_fields, clk, rst_n,
        !rsp_valid || rsp.evicted || (rsp.evicted_page == '0 && !rsp.evicted_dirty))
    `ASSERT_ALWAYS(a_hit_counted, clk, rst_n, !rsp_valid || !rsp.hit || rsp.hit_count != '0)

endmodule

bind lru_page_buffer_manager lpbm_checker u_lpbm_checker (.*);
